@@ rtl/core/vrt_pkg.sv @@
// Shared constants, types and command/status bundles of the voxel ray traversal block.
package vrt_pkg;

  localparam int COORD_BITS = 5;
  localparam int KIND_BITS  = 8;
  localparam int ADDR_BITS  = 3 * COORD_BITS;
  localparam int CELL_COUNT = 1 << ADDR_BITS;
  localparam int FRAC_BITS  = 16;
  localparam int ORG_BITS   = 23;
  localparam int DIR_BITS   = 18;
  localparam int MAG_BITS   = 18;
  localparam int MAXD_BITS  = 22;
  localparam int DIST_BITS  = 32;
  localparam int QUO_BITS   = 33;
  localparam int POS_BITS   = 8;
  localparam int IN_BITS    = 168;
  localparam int OUT_BITS   = 24;
  localparam int CNT_BITS   = 6;

  localparam logic [DIST_BITS-1:0] DIST_ONES = '1;

  typedef struct packed {
    logic                 capture;
    logic                 mem_we;
    logic                 mem_clear;
    logic [ADDR_BITS-1:0] clear_addr;
    logic [1:0]           axis;
    logic                 div_init;
    logic                 div_step;
    logic                 div_bit;
    logic                 mul;
    logic                 side_load;
    logic                 advance;
    logic                 res_hit;
    logic                 res_miss;
  } vrt_cmd_t;

  typedef struct packed {
    logic dist_over;
    logic in_grid;
    logic leaving;
    logic kind_nz;
  } vrt_stat_t;

endpackage

@@ rtl/core/vrt_ram.sv @@
// Generic simple dual-port RAM with registered read.
module vrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/vrt_datapath.sv @@
// Ray datapath: voxel store, shared divider, side-distance multiplier and DDA stepper.
module vrt_datapath (
  input  logic                        clk,
  input  logic [vrt_pkg::IN_BITS-1:0] in_data,
  input  vrt_pkg::vrt_cmd_t           cmd,
  output vrt_pkg::vrt_stat_t          stat,
  output logic [vrt_pkg::OUT_BITS-1:0] out_data
);
  import vrt_pkg::*;

  logic signed [POS_BITS-1:0]  pos   [3];
  logic [FRAC_BITS-1:0]        ofrac [3];
  logic signed [DIR_BITS-1:0]  dir   [3];
  logic [DIST_BITS-1:0]        delta [3];
  logic [DIST_BITS-1:0]        side  [3];
  logic [DIST_BITS-1:0]        travel;
  logic [MAXD_BITS-1:0]        maxd;
  logic [MAG_BITS-1:0]         rem;
  logic [QUO_BITS-1:0]         quo;
  logic [MAG_BITS+DIST_BITS-1:0] prod;
  logic [OUT_BITS-1:0]         res;

  logic [ADDR_BITS-1:0] waddr, raddr;
  logic [KIND_BITS-1:0] wdata, rdata;

  logic signed [DIR_BITS-1:0] dsel, dneg;
  logic [MAG_BITS-1:0]        mag, frac, ofrac_ext;
  logic [MAG_BITS:0]          rem_sh;
  logic [DIST_BITS-1:0]       dl;
  logic [1:0]                 adv;
  logic [DIST_BITS:0]         side_sum;
  logic [2:0]                 leave_ax;

  assign waddr = cmd.mem_clear ? cmd.clear_addr : in_data[14:0];
  assign wdata = cmd.mem_clear ? '0 : in_data[22:15];
  assign raddr = {pos[2][COORD_BITS-1:0], pos[1][COORD_BITS-1:0], pos[0][COORD_BITS-1:0]};

  vrt_ram #(.WIDTH(KIND_BITS), .DEPTH(CELL_COUNT)) u_store (
    .clk   (clk),
    .we    (cmd.mem_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Setup arithmetic for the axis under work.
  always_comb begin
    dsel      = dir[cmd.axis];
    dneg      = -dsel;
    mag       = dsel[DIR_BITS-1] ? dneg[MAG_BITS-1:0] : dsel[MAG_BITS-1:0];
    ofrac_ext = {{(MAG_BITS-FRAC_BITS){1'b0}}, ofrac[cmd.axis]};
    frac      = dsel[DIR_BITS-1] ? ofrac_ext : (MAG_BITS'(1) << FRAC_BITS) - ofrac_ext;
    rem_sh    = {rem, cmd.div_bit};
    dl        = quo[QUO_BITS-1] ? DIST_ONES : quo[DIST_BITS-1:0];
  end

  // Axis choice: y wins ties over x, z over y.
  always_comb begin
    if (side[0] < side[1] && side[0] < side[2]) begin
      adv = 2'd0;
    end else if (side[1] < side[2]) begin
      adv = 2'd1;
    end else begin
      adv = 2'd2;
    end
    side_sum = {1'b0, side[adv]} + {1'b0, delta[adv]};
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      leave_ax[a] = (pos[a] < 0 && dir[a] <= 0) ||
                    (pos[a] >= POS_BITS'(1 << COORD_BITS) && dir[a] >= 0);
    end
    stat.dist_over = travel > DIST_BITS'(maxd);
    stat.in_grid   = (pos[0][POS_BITS-1:COORD_BITS] == '0) &&
                     (pos[1][POS_BITS-1:COORD_BITS] == '0) &&
                     (pos[2][POS_BITS-1:COORD_BITS] == '0);
    stat.leaving   = |leave_ax;
    stat.kind_nz   = rdata != '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int a = 0; a < 3; a++) begin
        pos[a]   <= POS_BITS'($signed(in_data[23+23*a+22 -: 7]));
        ofrac[a] <= in_data[23+23*a +: FRAC_BITS];
        dir[a]   <= in_data[92+18*a +: DIR_BITS];
      end
      maxd   <= in_data[167:146];
      travel <= '0;
    end
    if (cmd.div_init) begin
      rem <= '0;
      quo <= '0;
    end
    if (cmd.div_step) begin
      if (rem_sh >= {1'b0, mag}) begin
        rem <= MAG_BITS'(rem_sh - {1'b0, mag});
        quo <= {quo[QUO_BITS-2:0], 1'b1};
      end else begin
        rem <= rem_sh[MAG_BITS-1:0];
        quo <= {quo[QUO_BITS-2:0], 1'b0};
      end
    end
    if (cmd.mul) begin
      prod <= frac * dl;
    end
    if (cmd.side_load) begin
      if (dsel == '0) begin
        delta[cmd.axis] <= DIST_ONES;
        side[cmd.axis]  <= DIST_ONES;
      end else begin
        delta[cmd.axis] <= dl;
        side[cmd.axis]  <= (|prod[MAG_BITS+DIST_BITS-1:FRAC_BITS+DIST_BITS]) ? DIST_ONES
                                                      : prod[FRAC_BITS +: DIST_BITS];
      end
    end
    if (cmd.advance) begin
      pos[adv]  <= dir[adv][DIR_BITS-1] ? pos[adv] - POS_BITS'(1) : pos[adv] + POS_BITS'(1);
      travel    <= side[adv];
      side[adv] <= side_sum[DIST_BITS] ? DIST_ONES : side_sum[DIST_BITS-1:0];
    end
    if (cmd.res_hit) begin
      res <= {rdata, pos[2][COORD_BITS-1:0], pos[1][COORD_BITS-1:0],
              pos[0][COORD_BITS-1:0], 1'b1};
    end else if (cmd.res_miss) begin
      res <= '0;
    end
  end

  assign out_data = res;

endmodule

@@ rtl/core/vrt_ctrl.sv @@
// Sequencer for clearing, writes, per-axis setup and the voxel walk.
module vrt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_cast,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  vrt_pkg::vrt_stat_t stat,
  output vrt_pkg::vrt_cmd_t  cmd
);
  import vrt_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_SIDE  = 3'd4;
  localparam logic [2:0] S_TEST  = 3'd5;
  localparam logic [2:0] S_CHECK = 3'd6;

  logic [2:0]           state, state_next;
  logic [ADDR_BITS-1:0] clr, clr_next;
  logic [1:0]           axis, axis_next;
  logic [CNT_BITS-1:0]  cnt, cnt_next;
  logic                 out_valid_next;
  logic                 out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    clr_next   = clr;
    axis_next  = axis;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.axis   = axis;
    cmd.clear_addr = clr;
    cmd.div_bit    = cnt == CNT_BITS'(QUO_BITS - 1);
    case (state)
      S_CLEAR: begin
        cmd.mem_we    = 1'b1;
        cmd.mem_clear = 1'b1;
        clr_next      = clr + 1'b1;
        if (clr == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_cast) begin
            cmd.capture  = 1'b1;
            cmd.div_init = 1'b1;
            axis_next    = 2'd0;
            cnt_next     = CNT_BITS'(QUO_BITS - 1);
            state_next   = S_DIV;
          end else begin
            cmd.mem_we = 1'b1;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt - 1'b1;
        if (cnt == '0) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SIDE;
      end
      S_SIDE: begin
        cmd.side_load = 1'b1;
        cmd.div_init  = 1'b1;
        cnt_next      = CNT_BITS'(QUO_BITS - 1);
        if (axis == 2'd2) begin
          state_next = S_TEST;
        end else begin
          axis_next  = axis + 1'b1;
          state_next = S_DIV;
        end
      end
      S_TEST: begin
        if (stat.dist_over || (!stat.in_grid && stat.leaving)) begin
          if (out_free) begin
            cmd.res_miss = 1'b1;
            state_next   = S_IDLE;
          end
        end else if (stat.in_grid) begin
          state_next = S_CHECK;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_CHECK: begin
        if (stat.kind_nz) begin
          if (out_free) begin
            cmd.res_hit = 1'b1;
            state_next  = S_IDLE;
          end
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_TEST;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (cmd.res_hit || cmd.res_miss) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      axis      <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr       <= clr_next;
      axis      <= axis_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ rtl/core/voxel_ray_traversal.sv @@
// Top level of the voxel ray traversal block: 3D DDA walk through a 32x32x32 voxel grid.
//
// Channel  Direction  Handshake                  Contents
// s_axis   in         s_axis_tvalid/tready       tuser opcode; tdata write or cast fields
// m_axis   out        m_axis_tvalid/tready       tdata hit, hit_x/y/z, hit_kind
//
// After reset the controller sweeps all 32768 voxel store entries to air, one entry a
// cycle, with s_axis_tready low. A write transaction is stored as it is accepted.
// A cast runs setup for each axis in turn (one quotient bit a cycle in the shared divider,
// then one multiply and one load), then tests each voxel in S_TEST; for an in-grid one
// the kind is read from the store in S_CHECK (registered read), and an out-of-grid one
// is stepped past. A finished result waits in the output register; the next transaction
// is taken meanwhile, and a cast stalls at its end until the register frees.
module voxel_ray_traversal (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata: voxel_x, voxel_y, voxel_z, voxel_kind, origin_x, origin_y, origin_z,
  //        dir_x, dir_y, dir_z, max_distance
  input  logic [vrt_pkg::IN_BITS-1:0]  s_axis_tdata,
  // tuser: opcode
  input  logic                         s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // tdata: hit, hit_x, hit_y, hit_z, hit_kind
  output logic [vrt_pkg::OUT_BITS-1:0] m_axis_tdata
);
  import vrt_pkg::*;

  vrt_cmd_t  cmd;
  vrt_stat_t stat;

  // Sequence the work; a write lands in the store in the accepting cycle.
  vrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_cast   (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold ray state, divider, multiplier and the voxel store.
  vrt_datapath u_dp (
    .clk      (clk),
    .in_data  (s_axis_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (m_axis_tdata)
  );

endmodule
